// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define IFPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ifpd check failed");

// Clocked check that also holds during reset.
`define IFPD_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ifpd reset check failed");

`endif

// ===== src/ifpd_pkg.sv =====
`default_nettype none

package ifpd_pkg;

  localparam int unsigned MaxLen = 11;

  typedef logic [MaxLen-1:0][7:0] win_t;

  localparam logic [7:0] OpIncA  = 8'h18;
  localparam logic [7:0] OpIncB  = 8'h19;
  localparam logic [7:0] OpInt   = 8'h84;
  localparam logic [7:0] OpExit  = 8'h6F;
  localparam logic [7:0] OpRetn  = 8'h6E;
  localparam logic [7:0] OpRet   = 8'h6D;
  localparam logic [7:0] OpCall  = 8'h6C;
  localparam logic [7:0] OpBrLo  = 8'h60;
  localparam logic [7:0] OpBrHi  = 8'h70;

  typedef enum logic [4:0] {
    FormNone      = 5'd0,
    FormIncDec    = 5'd1,
    FormInt       = 5'd2,
    FormExitImm   = 5'd3,
    FormExitReg   = 5'd4,
    FormRetn      = 5'd5,
    FormRet       = 5'd6,
    FormCall      = 5'd7,
    FormBranch    = 5'd8,
    FormRegBranch = 5'd9,
    FormThreeRegs = 5'd10,
    FormRegImmReg = 5'd11,
    FormTwoRegs   = 5'd12,
    FormImmReg    = 5'd13,
    FormOneReg    = 5'd14,
    FormImm       = 5'd15,
    FormUnknown   = 5'd16
  } form_e;

  typedef struct packed {
    logic sel_in;  // window includes the incoming word
    logic append;  // store incoming word
    logic retire;  // incoming word completes an instruction
    logic step;    // resolve one result at end of buffer
  } cmd_t;

  typedef struct packed {
    logic good;    // complete instruction at window head
    logic last;    // this step empties the buffer
  } sts_t;

  function automatic logic [1:0] reg_count(input logic [7:0] mode);
    logic [1:0] sub;
    sub = {1'b0, mode[5]} + {1'b0, mode[4]};
    if (mode[7:6] > sub) begin
      return mode[7:6] - sub;
    end
    return 2'd0;
  endfunction

  function automatic logic [3:0] insn_len(input logic [7:0] mode);
    return 4'd2 + (mode[3] ? 4'd3 : 4'd0) + {2'b00, reg_count(mode)}
         + (mode[5] ? 4'd4 : 4'd0);
  endfunction

endpackage

`default_nettype wire

// ===== src/ifpd_in_if.sv =====
`default_nettype none

interface ifpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_buffer;

  modport source (output valid, output code_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input code_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ===== src/ifpd_out_if.sv =====
`default_nettype none

interface ifpd_out_if;
  logic               valid;
  logic               ready;
  logic               is_error;
  logic [31:0]        insn_address;
  logic [3:0]         insn_length;
  logic [7:0]         opcode;
  logic [7:0]         mode_byte;
  logic [23:0]        ext_classes;
  logic [7:0]         reg_first;
  logic [7:0]         reg_second;
  logic [7:0]         reg_third;
  logic signed [31:0] immediate;
  logic [4:0]         operand_form;

  modport source (
    output valid, input ready,
    output is_error, output insn_address, output insn_length, output opcode,
    output mode_byte, output ext_classes, output reg_first, output reg_second,
    output reg_third, output immediate, output operand_form
  );
  modport sink (
    input valid, output ready,
    input is_error, input insn_address, input insn_length, input opcode,
    input mode_byte, input ext_classes, input reg_first, input reg_second,
    input reg_third, input immediate, input operand_form
  );
endinterface

`default_nettype wire

// ===== src/ifpd_ctrl.sv =====
`default_nettype none

module ifpd_ctrl import ifpd_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  input  wire  logic end_of_buffer_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  localparam logic StAccept = 1'b0;
  localparam logic StDrain  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free, acc, load;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StAccept) && slot_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.sel_in = (state_q == StAccept);
    cmd_o.append = acc && (end_of_buffer_i || !sts_i.good);
    cmd_o.retire = acc && !end_of_buffer_i && sts_i.good;
    cmd_o.step   = (state_q == StDrain) && slot_free;
  end

  assign load = cmd_o.retire || cmd_o.step;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StAccept: begin
        if (acc && end_of_buffer_i) state_d = StDrain;
      end
      StDrain: begin
        if (cmd_o.step && sts_i.last) state_d = StAccept;
      end
      default: state_d = StAccept;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAccept;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/ifpd_datapath.sv =====
`default_nettype none

module ifpd_datapath import ifpd_pkg::*; (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        cfg_we_i,
  input  wire  logic [31:0] cfg_wdata_i,
  input  wire  logic [7:0]  code_byte_i,
  input  wire  cmd_t        cmd_i,
  output sts_t              sts_o,
  output logic              is_error_o,
  output logic [31:0]       insn_address_o,
  output logic [3:0]        insn_length_o,
  output logic [7:0]        opcode_o,
  output logic [7:0]        mode_byte_o,
  output logic [23:0]       ext_classes_o,
  output logic [7:0]        reg_first_o,
  output logic [7:0]        reg_second_o,
  output logic [7:0]        reg_third_o,
  output logic signed [31:0] immediate_o,
  output logic [4:0]        operand_form_o
);

  logic [31:0] base_q;
  win_t        buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] off_q, off_d;

  win_t        view;
  logic [3:0]  vcnt;
  logic [7:0]  op, mode;
  logic [3:0]  len, shamt, rem;
  logic [1:0]  nregs;
  logic [3:0]  rbase, ipos;
  logic        good;
  logic [7:0]  rv [3];
  logic [31:0] imm;
  logic [23:0] ext;
  form_e       form;
  logic        load;

  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      if (cmd_i.sel_in && (cnt_q == 4'(i))) begin
        view[i] = code_byte_i;
      end else begin
        view[i] = buf_q[i];
      end
    end
  end

  assign vcnt  = cmd_i.sel_in ? cnt_q + 4'd1 : cnt_q;
  assign op    = view[0];
  assign mode  = view[1];
  assign len   = insn_len(mode);
  assign nregs = reg_count(mode);
  assign good  = (vcnt >= 4'd2) && (len <= vcnt);
  assign shamt = good ? len : 4'd1;
  assign rem   = vcnt - shamt;
  assign rbase = mode[3] ? 4'd5 : 4'd2;
  assign ipos  = rbase + {2'b00, nregs};
  assign ext   = mode[3] ? {view[2], view[3], view[4]} : 24'd0;
  assign imm   = mode[5] ? {view[ipos + 4'd3], view[ipos + 4'd2],
                            view[ipos + 4'd1], view[ipos]} : 32'd0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rv[k] = (2'(k) < nregs) ? view[rbase + 4'(k)] : 8'd0;
    end
  end

  always_comb begin
    priority if (mode[7:6] == 2'd0)           form = FormNone;
    else if (op == OpIncA || op == OpIncB)    form = FormIncDec;
    else if (op == OpInt)                     form = FormInt;
    else if (op == OpExit)                    form = mode[5] ? FormExitImm : FormExitReg;
    else if (op == OpRetn)                    form = FormRetn;
    else if (op == OpRet)                     form = FormRet;
    else if (op == OpCall)                    form = FormCall;
    else if (op >= OpBrLo && op <= OpBrHi)    form = (nregs == 2'd0) ? FormBranch
                                                                     : FormRegBranch;
    else if (nregs == 2'd3 && !mode[5])       form = FormThreeRegs;
    else if (nregs == 2'd2 && mode[5])        form = FormRegImmReg;
    else if (nregs == 2'd2)                   form = FormTwoRegs;
    else if (nregs == 2'd1 && mode[5])        form = FormImmReg;
    else if (nregs == 2'd1)                   form = FormOneReg;
    else if (mode[5])                         form = FormImm;
    else                                      form = FormUnknown;
  end

  assign sts_o.good = good;
  assign sts_o.last = (rem == 4'd0);
  assign load       = cmd_i.retire || cmd_i.step;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    off_d = off_q;
    if (cmd_i.append) begin
      buf_d = view;
      cnt_d = vcnt;
    end
    if (cmd_i.retire) begin
      cnt_d = 4'd0;
      off_d = off_q + {28'd0, len};
    end
    if (cmd_i.step) begin
      for (int i = 0; i < MaxLen; i++) begin
        if (5'(i) + {1'b0, shamt} < 5'(MaxLen)) begin
          buf_d[i] = buf_q[4'(i) + shamt];
        end
      end
      if (sts_o.last) begin
        cnt_d = 4'd0;
        off_d = 32'd0;
      end else begin
        cnt_d = rem;
        off_d = off_q + {28'd0, shamt};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
      cnt_q  <= 4'd0;
      off_q  <= 32'd0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (load) begin
      is_error_o     <= !good;
      insn_address_o <= base_q + off_q;
      insn_length_o  <= shamt;
      opcode_o       <= op;
      mode_byte_o    <= good ? mode : 8'd0;
      ext_classes_o  <= good ? ext : 24'd0;
      reg_first_o    <= good ? rv[0] : 8'd0;
      reg_second_o   <= good ? rv[1] : 8'd0;
      reg_third_o    <= good ? rv[2] : 8'd0;
      immediate_o    <= good ? signed'(imm) : 32'sd0;
      operand_form_o <= good ? 5'(form) : 5'(FormNone);
    end
  end

endmodule

`default_nettype wire

// ===== src/instruction_field_predecoder_top.sv =====
// Instruction field predecoder.
// in_if carries one code byte per word plus an end_of_buffer flag; out_if
// carries one decoded instruction (or a one-byte error) per word. cfg_we_i /
// cfg_wdata_i write base_address; write it only while the block is idle.
// Throughput: one input word per cycle while the output is free and no drain
// runs. A word that completes an instruction loads the output register at
// its accept edge, so the result is valid the next cycle. A word with
// end_of_buffer set starts a drain that resolves the buffered bytes in the
// single decode window, one result per cycle while the receiver takes them;
// no input is taken meanwhile; offsets restart at base_address afterward.
// Reset clears the byte count, offset, base_address and output valid.
// When the receiver stalls, the result holds in the output register and
// input is refused until it is taken; a word is still accepted in the same
// cycle a waiting result leaves.
`default_nettype none

module instruction_field_predecoder_top import ifpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  ifpd_in_if.sink          in_if,
  ifpd_out_if.source       out_if
);

  cmd_t cmd;
  sts_t sts;

  ifpd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .end_of_buffer_i (in_if.end_of_buffer),
    .in_ready_o      (in_if.ready),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  ifpd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .code_byte_i    (in_if.code_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .is_error_o     (out_if.is_error),
    .insn_address_o (out_if.insn_address),
    .insn_length_o  (out_if.insn_length),
    .opcode_o       (out_if.opcode),
    .mode_byte_o    (out_if.mode_byte),
    .ext_classes_o  (out_if.ext_classes),
    .reg_first_o    (out_if.reg_first),
    .reg_second_o   (out_if.reg_second),
    .reg_third_o    (out_if.reg_third),
    .immediate_o    (out_if.immediate),
    .operand_form_o (out_if.operand_form)
  );

endmodule

`default_nettype wire

// ===== src/ifpd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module ifpd_checker import ifpd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       is_error_i,
  input wire logic [3:0] insn_length_i,
  input wire logic [7:0] mode_byte_i,
  input wire logic [4:0] operand_form_i
);

  logic err_zero, len_ok;

  assign err_zero = (insn_length_i == 4'd1) && (mode_byte_i == 8'd0)
                 && (operand_form_i == FormNone);
  assign len_ok   = (insn_length_i >= 4'd2) && (insn_length_i <= 4'(MaxLen));

  `IFPD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `IFPD_ASSERT(a_err_fields, out_valid_i && is_error_i |-> err_zero)
  `IFPD_ASSERT(a_len_range, out_valid_i && !is_error_i |-> len_ok)
  `IFPD_ASSERT(a_no_take_full, out_valid_i && !out_ready_i |-> !in_ready_i)
  `IFPD_ASSERT_NR(a_reset_quiet, !rst_ni |-> !out_valid_i)

endmodule

bind instruction_field_predecoder_top ifpd_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .is_error_i     (out_if.is_error),
  .insn_length_i  (out_if.insn_length),
  .mode_byte_i    (out_if.mode_byte),
  .operand_form_i (out_if.operand_form)
);

`default_nettype wire
